// ===== rtl/time_window_hit_clusterer_macros.svh =====
`ifndef TIME_WINDOW_HIT_CLUSTERER_MACROS_SVH
`define TIME_WINDOW_HIT_CLUSTERER_MACROS_SVH

// same-cycle implication
`define TWHC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("twhc assertion failed");

// next-cycle implication
`define TWHC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("twhc assertion failed");

`endif

// ===== rtl/twhc_pkg.sv =====
package twhc_pkg;

  localparam int TIME_W   = 32;
  localparam int ENERGY_W = 16;
  localparam int POS_W    = 24;
  localparam int CHAN_W   = 10;
  localparam int ESUM_W   = 22;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 32;

  localparam int RES_LIMIT = 64;
  localparam logic [ESUM_W-1:0] ENERGY_MAX = '1;
  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd16;

  localparam int DEF_MAX_HITS     = 64;
  localparam int DEF_CHANNEL_BITS = 10;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 1'd1;

  typedef struct packed {
    logic [CHAN_W-1:0]       channel_id;
    logic                    channel_null;
    logic [TIME_W-1:0]       hit_time;
    logic [ENERGY_W-1:0]     hit_energy;
    logic signed [POS_W-1:0] long_pos;
    logic                    batch_end;
  } hit_t;

  typedef struct packed {
    logic [CHAN_W-1:0]       cluster_channel;
    logic [ESUM_W-1:0]       cluster_energy;
    logic [TIME_W-1:0]       cluster_time;
    logic signed [POS_W-1:0] cluster_pos;
    logic [IDX_W-1:0]        cluster_index;
    logic                    cluster_valid;
    logic                    last_result;
  } cluster_t;

endpackage

// ===== rtl/twhc_ifs.sv =====
interface twhc_hit_if;
  import twhc_pkg::*;
  logic valid;
  logic ready;
  hit_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface twhc_cluster_if;
  import twhc_pkg::*;
  logic     valid;
  logic     ready;
  cluster_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/twhc_div.sv =====
`include "time_window_hit_clusterer_macros.svh"

module twhc_div #(
  parameter int DW = 54,
  parameter int VW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dv;
  logic [VW:0]   trial;
  logic          ge;

  assign trial    = {rem, quo[DW-1]};
  assign ge       = trial >= {1'b0, dv};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dv  <= divisor;
    end else if (busy) begin
      rem <= ge ? VW'(trial - {1'b0, dv}) : VW'(trial);
      quo <= {quo[DW-2:0], ge};
    end
  end

  `TWHC_ASSERT_IMP(a_div_nonzero, start, divisor != '0)
  `TWHC_ASSERT_IMP(a_div_idle_start, start, !busy)
  `TWHC_ASSERT_IMP(a_div_done_idle, done, !busy)

endmodule

// ===== rtl/time_window_hit_clusterer.sv =====
// channel   dir  handshake        payload
// hits      in   valid / ready    channel_id .. batch_end
// clusters  out  valid / ready    cluster_channel .. last_result
// cfg       in   cfg_we           cfg_index, cfg_data
//
// hits load at one per cycle into the hit memory; ready is held low from batch end
// until the last result of the batch sits in the output register
// clustering: per window a search pass and, if a hit is found, a sum pass; for a cluster
// over threshold a marking pass plus, below RES_LIMIT results, two divisions on the shared divider
// reset is synchronous and needs no clearing pass; hit memory is tracked by a fill count
// a finished cluster is held one deep so last_result can be set; the sequencer waits
// while the output register is stalled
`include "time_window_hit_clusterer_macros.svh"

module time_window_hit_clusterer #(
  parameter int MAX_HITS     = twhc_pkg::DEF_MAX_HITS,
  parameter int CHANNEL_BITS = twhc_pkg::DEF_CHANNEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  twhc_hit_if.sink                       hits,
  twhc_cluster_if.source                 clusters,
  input  logic                           cfg_we,
  input  logic [twhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [twhc_pkg::CFG_W-1:0]     cfg_data
);
  import twhc_pkg::*;

  localparam int AW   = $clog2(MAX_HITS);
  localparam int CNTW = $clog2(MAX_HITS + 1);
  localparam int EW   = ENERGY_W + CNTW;
  localparam int TW   = TIME_W + ENERGY_W + CNTW;
  localparam int PW   = POS_W + ENERGY_W + CNTW;
  localparam int TPW  = TIME_W + ENERGY_W;
  localparam int PPW  = POS_W + ENERGY_W;
  localparam int NW   = $clog2(RES_LIMIT + 1);
  localparam int CCW  = (CHANNEL_BITS < CHAN_W) ? CHANNEL_BITS : CHAN_W;
  localparam int CMPW = (EW > ESUM_W) ? EW : ESUM_W;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_OUTER = 9'b000000010,
    S_OCHK  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_DIVT  = 9'b000010000,
    S_DIVP  = 9'b000100000,
    S_PUSH  = 9'b001000000,
    S_FINAL = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    M_FIND = 3'b001,
    M_SUM  = 3'b010,
    M_MARK = 3'b100
  } mode_t;

  typedef struct packed {
    logic [TIME_W-1:0]       t;
    logic [ENERGY_W-1:0]     e;
    logic [CHANNEL_BITS-1:0] ch;
    logic signed [POS_W-1:0] p;
  } rec_t;

  rec_t hmem [MAX_HITS];
  logic cmem [MAX_HITS];

  state_t state;
  mode_t  mode;
  logic [CNTW-1:0] cnt, i, ra;
  logic [AW-1:0]   pa, first;
  logic            pv, found, s1v, hv, out_v;
  logic [NW-1:0]   nres;
  logic [TIME_W-1:0] tw;
  logic [ESUM_W-1:0] thr;

  logic [CHANNEL_BITS-1:0] ch, ch_in;
  logic [TIME_W-1:0]       best, res_time;
  logic [TIME_W:0]         limit;
  logic [EW-1:0]           esum;
  logic [TW-1:0]           tsum;
  logic signed [PW-1:0]    psum;
  logic [ENERGY_W-1:0]     s1e;
  logic [TPW-1:0]          s1tp;
  logic signed [PPW-1:0]   s1pp;
  cluster_t nc, held, out_data, out_next;

  rec_t rec_in, rd_rec;
  logic rd_cons, rd_en;
  logic [AW-1:0] rd_addr;
  logic hm_we, cm_we, cm_wd;
  logic [AW-1:0] cm_wa;

  logic acc, store, match, in_win, better, exceed, scan_done, ov_free, out_load;
  logic start_find, start_sum, start_mark, next_outer, start_divt;

  logic          div_start, div_busy, div_done;
  logic [TW-1:0] div_dividend, div_quo;
  logic [PW-1:0] pmag;
  logic [POS_W-1:0] qpos;

  assign acc    = hits.valid && hits.ready;
  assign store  = !hits.data.channel_null && (cnt < CNTW'(MAX_HITS));
  assign hm_we  = acc && store;
  assign ch_in  = CHANNEL_BITS'(hits.data.channel_id[CCW-1:0]);
  assign rec_in = '{t: hits.data.hit_time, e: hits.data.hit_energy, ch: ch_in,
                    p: hits.data.long_pos};
  assign hits.ready = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (hm_we) hmem[cnt[AW-1:0]] <= rec_in;
    if (rd_en) rd_rec <= hmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cmem[cm_wa] <= cm_wd;
    if (rd_en) rd_cons <= cmem[rd_addr];
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ra[AW-1:0];
    if (state == S_OUTER) begin
      rd_en   = (i != cnt);
      rd_addr = i[AW-1:0];
    end else if (state == S_SCAN) begin
      rd_en = (ra < cnt);
    end
  end

  assign match     = pv && !rd_cons && (rd_rec.ch == ch);
  assign in_win    = {1'b0, rd_rec.t} < limit;
  assign better    = match && (!found || rd_rec.t < best);
  assign exceed    = CMPW'(esum) > CMPW'(thr);
  assign scan_done = (state == S_SCAN) && (ra == cnt) && !pv && !s1v;
  assign ov_free   = !out_v || clusters.ready;

  assign start_sum  = scan_done && mode == M_FIND && found;
  assign start_mark = scan_done && mode == M_SUM && exceed;
  assign start_divt = scan_done && mode == M_MARK && nres < NW'(RES_LIMIT);
  assign start_find = (state == S_OCHK && !rd_cons)
                   || (scan_done && mode == M_SUM && !exceed)
                   || (scan_done && mode == M_MARK && nres >= NW'(RES_LIMIT))
                   || (state == S_PUSH && (!hv || ov_free));
  assign next_outer = (state == S_OCHK && rd_cons)
                   || (scan_done && mode == M_FIND && !found);
  assign out_load   = (state == S_PUSH && hv && ov_free) || (state == S_FINAL && ov_free);

  always_comb begin
    cm_we = 1'b0;
    cm_wa = first;
    cm_wd = 1'b1;
    if (hm_we) begin
      cm_we = 1'b1;
      cm_wa = cnt[AW-1:0];
      cm_wd = 1'b0;
    end else if (state == S_SCAN && mode == M_MARK && match && in_win) begin
      cm_we = 1'b1;
      cm_wa = pa;
    end else if (scan_done && mode == M_SUM && !exceed) begin
      cm_we = 1'b1;
    end
  end

  always_comb begin
    out_next = held;
    if (state == S_FINAL) begin
      if (!hv) out_next = '0;
      out_next.last_result = 1'b1;
    end
  end

  assign pmag         = psum[PW-1] ? PW'(-psum) : PW'(psum);
  assign div_start    = start_divt || (state == S_DIVT && div_done);
  assign div_dividend = (state == S_DIVT) ? TW'(pmag) : tsum;
  assign qpos         = div_quo[POS_W-1:0];

  twhc_div #(.DW(TW), .VW(EW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (esum),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      mode  <= M_FIND;
      cnt   <= '0;
      i     <= '0;
      ra    <= '0;
      pv    <= 1'b0;
      found <= 1'b0;
      s1v   <= 1'b0;
      hv    <= 1'b0;
      nres  <= '0;
      out_v <= 1'b0;
      tw    <= WINDOW_RESET;
      thr   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_WINDOW:      tw  <= cfg_data;
          REG_ENERGY_THRESHOLD: thr <= cfg_data[ESUM_W-1:0];
          default: ;
        endcase
      end
      if (out_v && clusters.ready) out_v <= 1'b0;
      if (out_load) out_v <= 1'b1;
      pv  <= (state == S_SCAN) && (ra < cnt);
      s1v <= (state == S_SCAN) && (mode == M_SUM) && match && in_win;
      if (state == S_SCAN && ra < cnt) ra <= ra + 1'b1;
      if (state == S_SCAN && mode == M_FIND && better) found <= 1'b1;
      unique case (state)
        S_LOAD: begin
          if (acc) begin
            if (store) cnt <= cnt + 1'b1;
            if (hits.data.batch_end) begin
              i     <= '0;
              state <= S_OUTER;
            end
          end
        end
        S_OUTER: state <= (i == cnt) ? S_FINAL : S_OCHK;
        S_DIVT:  if (div_done) state <= S_DIVP;
        S_DIVP:  if (div_done) state <= S_PUSH;
        S_PUSH: begin
          if (!hv || ov_free) begin
            hv   <= 1'b1;
            nres <= nres + 1'b1;
          end
        end
        S_FINAL: begin
          if (ov_free) begin
            hv    <= 1'b0;
            cnt   <= '0;
            nres  <= '0;
            state <= S_LOAD;
          end
        end
        default: ;
      endcase
      if (start_find) begin
        ra    <= i;
        found <= 1'b0;
        mode  <= M_FIND;
        state <= S_SCAN;
      end
      if (start_sum) begin
        ra   <= i;
        mode <= M_SUM;
      end
      if (start_mark) begin
        ra   <= i;
        mode <= M_MARK;
      end
      if (start_divt) state <= S_DIVT;
      if (next_outer) begin
        i     <= i + 1'b1;
        state <= S_OUTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    pa   <= ra[AW-1:0];
    s1e  <= rd_rec.e;
    s1tp <= TPW'(rd_rec.t) * TPW'(rd_rec.e);
    s1pp <= PPW'(rd_rec.p) * PPW'($signed({1'b0, rd_rec.e}));
    if (state == S_SCAN && mode == M_FIND && better) begin
      best  <= rd_rec.t;
      first <= pa;
    end
    if (state == S_OCHK && !rd_cons) ch <= rd_rec.ch;
    if (start_sum) begin
      limit <= {1'b0, best} + {1'b0, tw};
      esum  <= '0;
      tsum  <= '0;
      psum  <= '0;
    end else if (s1v) begin
      esum <= esum + EW'(s1e);
      tsum <= tsum + TW'(s1tp);
      psum <= psum + PW'(s1pp);
    end
    if (state == S_DIVT && div_done) res_time <= div_quo[TIME_W-1:0];
    if (state == S_DIVP && div_done) begin
      nc.cluster_channel <= CHAN_W'(ch[CCW-1:0]);
      nc.cluster_energy  <= (CMPW'(esum) > CMPW'(ENERGY_MAX)) ? ENERGY_MAX : ESUM_W'(esum);
      nc.cluster_time    <= res_time;
      nc.cluster_pos     <= psum[PW-1] ? -qpos : qpos;
      nc.cluster_index   <= nres[IDX_W-1:0];
      nc.cluster_valid   <= 1'b1;
      nc.last_result     <= 1'b0;
    end
    if (state == S_PUSH && (!hv || ov_free)) held <= nc;
    if (out_load) out_data <= out_next;
  end

  assign clusters.valid = out_v;
  assign clusters.data  = out_data;

  `TWHC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CNTW'(MAX_HITS))
  `TWHC_ASSERT_IMP(a_no_collide, cm_we && rd_en, cm_wa != rd_addr)
  `TWHC_ASSERT_IMP(a_nres_bound, 1'b1, nres <= NW'(RES_LIMIT))
  `TWHC_ASSERT_IMP(a_div_only_divide, div_busy, state == S_DIVT || state == S_DIVP)

endmodule

// ===== sim/time_window_hit_clusterer_checker.sv =====
`timescale 1ns / 100ps

module time_window_hit_clusterer_checker
  import twhc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  twhc_hit_if                  hits,
  twhc_cluster_if              clusters,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fails,
  output int                   pending,
  output int                   checked
);

  logic [TIME_W-1:0]       time_mem [DEF_MAX_HITS];
  logic [ENERGY_W-1:0]     energy_mem [DEF_MAX_HITS];
  logic [CHAN_W-1:0]       chan_mem [DEF_MAX_HITS];
  logic signed [POS_W-1:0] pos_mem [DEF_MAX_HITS];
  bit                      taken [DEF_MAX_HITS];
  int                      fill;
  logic [TIME_W-1:0]       window;
  logic [ESUM_W-1:0]       threshold;
  cluster_t                expected_clusters [$];

  initial begin
    fails = 0;
    pending = 0;
    checked = 0;
  end

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic form_clusters();
    cluster_t          batch [$];
    cluster_t          c;
    logic [CHAN_W-1:0] ch;
    logic [63:0]       esum;
    logic [63:0]       tsum;
    logic [63:0]       lim;
    longint            psum;
    int                first;
    for (int i = 0; i < fill; i++) begin
      if (taken[i]) continue;
      ch = chan_mem[i];
      forever begin
        first = -1;
        for (int j = i; j < fill; j++) begin
          if (taken[j] || chan_mem[j] != ch) continue;
          if (first < 0 || time_mem[j] < time_mem[first]) first = j;
        end
        if (first < 0) break;
        lim = {32'b0, time_mem[first]} + {32'b0, window};
        esum = 0;
        tsum = 0;
        psum = 0;
        for (int j = i; j < fill; j++) begin
          if (taken[j] || chan_mem[j] != ch) continue;
          if ({32'b0, time_mem[j]} < lim) begin
            esum += {48'b0, energy_mem[j]};
            tsum += {32'b0, time_mem[j]} * {48'b0, energy_mem[j]};
            psum += longint'(pos_mem[j]) * longint'({48'b0, energy_mem[j]});
          end
        end
        if (esum > {42'b0, threshold}) begin
          for (int j = i; j < fill; j++)
            if (!taken[j] && chan_mem[j] == ch && {32'b0, time_mem[j]} < lim)
              taken[j] = 1;
          if (batch.size() < RES_LIMIT) begin
            c = '0;
            c.cluster_channel = ch;
            c.cluster_energy = (esum > {42'b0, ENERGY_MAX}) ? ENERGY_MAX : esum[ESUM_W-1:0];
            c.cluster_time = TIME_W'(tsum / esum);
            c.cluster_pos = POS_W'(psum / longint'(esum));
            c.cluster_index = IDX_W'(batch.size());
            c.cluster_valid = 1'b1;
            batch = {batch, c};
          end
        end else begin
          taken[first] = 1;
        end
      end
    end
    if (batch.size() == 0) batch = {batch, cluster_t'('0)};
    batch[batch.size()-1].last_result = 1'b1;
    expected_clusters = {expected_clusters, batch};
    fill = 0;
    foreach (taken[k]) taken[k] = 0;
  endtask

  task automatic compare_cluster(input cluster_t got);
    cluster_t exp_c;
    if (expected_clusters.size() == 0) begin
      report($sformatf("unexpected cluster %p", got));
      return;
    end
    exp_c = expected_clusters.pop_front();
    checked++;
    if (got.cluster_channel !== exp_c.cluster_channel)
      report($sformatf("channel %0d, want %0d", got.cluster_channel, exp_c.cluster_channel));
    if (got.cluster_energy !== exp_c.cluster_energy)
      report($sformatf("energy %0d, want %0d", got.cluster_energy, exp_c.cluster_energy));
    if (got.cluster_time !== exp_c.cluster_time)
      report($sformatf("time %0d, want %0d", got.cluster_time, exp_c.cluster_time));
    if (got.cluster_pos !== exp_c.cluster_pos)
      report($sformatf("pos %0d, want %0d", got.cluster_pos, exp_c.cluster_pos));
    if (got.cluster_index !== exp_c.cluster_index)
      report($sformatf("index %0d, want %0d", got.cluster_index, exp_c.cluster_index));
    if (got.cluster_valid !== exp_c.cluster_valid)
      report($sformatf("valid %0b, want %0b", got.cluster_valid, exp_c.cluster_valid));
    if (got.last_result !== exp_c.last_result)
      report($sformatf("last %0b, want %0b", got.last_result, exp_c.last_result));
  endtask

  always @(posedge clk) begin
    hit_t h;
    if (rst) begin
      fill = 0;
      foreach (taken[k]) taken[k] = 0;
      window = WINDOW_RESET;
      threshold = '0;
      expected_clusters.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_WINDOW:      window = cfg_data[TIME_W-1:0];
          REG_ENERGY_THRESHOLD: threshold = cfg_data[ESUM_W-1:0];
          default: ;
        endcase
      end
      if (hits.valid && hits.ready) begin
        h = hits.data;
        if (!h.channel_null && fill < DEF_MAX_HITS) begin
          time_mem[fill] = h.hit_time;
          energy_mem[fill] = h.hit_energy;
          chan_mem[fill] = h.channel_id;
          pos_mem[fill] = h.long_pos;
          taken[fill] = 0;
          fill++;
        end
        if (h.batch_end) form_clusters();
      end
      if (clusters.valid && clusters.ready) compare_cluster(clusters.data);
    end
    pending = expected_clusters.size();
  end

endmodule

// ===== sim/time_window_hit_clusterer_tb.sv =====
`timescale 1ns / 100ps

module time_window_hit_clusterer_tb;
  import twhc_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fails;
  int                   pending;
  int                   checked;
  int                   idle_mode;
  int                   hits_sent;
  int                   batches_sent;

  twhc_hit_if     hits ();
  twhc_cluster_if clusters ();

  time_window_hit_clusterer dut (
    .clk       (clk),
    .rst       (rst),
    .hits      (hits),
    .clusters  (clusters),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  time_window_hit_clusterer_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .hits      (hits),
    .clusters  (clusters),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // idle modes: 0 none, 1 sender 70%, 2 receiver 70%, 3 both 7%
  always @(posedge clk) begin
    if (rst) begin
      clusters.ready <= 1'b0;
    end else if (idle_mode == 2) begin
      clusters.ready <= $urandom_range(0, 99) >= 70;
    end else if (idle_mode == 3) begin
      clusters.ready <= $urandom_range(0, 99) >= 7;
    end else begin
      clusters.ready <= 1'b1;
    end
  end

  function automatic hit_t make_hit(input logic [CHAN_W-1:0] ch, input logic nul,
                                    input logic [TIME_W-1:0] t,
                                    input logic [ENERGY_W-1:0] e,
                                    input logic [POS_W-1:0] p, input logic last);
    hit_t h;
    h.channel_id = ch;
    h.channel_null = nul;
    h.hit_time = t;
    h.hit_energy = e;
    h.long_pos = p;
    h.batch_end = last;
    return h;
  endfunction

  task automatic send_hit(input hit_t h);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == 1) ? 70 : (idle_mode == 3) ? 7 : 0;
    while ($urandom_range(0, 99) < pct) gap++;
    if (gap > 0) begin
      hits.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hits.valid <= 1'b1;
    hits.data <= h;
    do @(posedge clk); while (!hits.ready);
    hits_sent++;
    if (h.batch_end) batches_sent++;
  endtask

  task automatic wait_drained();
    hits.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [TIME_W-1:0] tw, input logic [ESUM_W-1:0] thr);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_TIME_WINDOW;
    cfg_data <= tw;
    @(posedge clk);
    cfg_index <= REG_ENERGY_THRESHOLD;
    cfg_data <= CFG_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_batch(input int n);
    logic [CHAN_W-1:0] pool [3];
    logic [TIME_W-1:0] base;
    int                span;
    logic [ENERGY_W-1:0] e;
    for (int k = 0; k < 3; k++)
      pool[k] = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, 1023))
                                            : CHAN_W'($urandom_range(0, 7));
    case ($urandom_range(0, 7))
      0: base = 32'hFFFF_FF00;
      1, 2: base = $urandom;
      default: base = $urandom_range(0, 1000);
    endcase
    case ($urandom_range(0, 2))
      0: span = 20;
      1: span = 100;
      default: span = 2000;
    endcase
    for (int k = 0; k < n; k++) begin
      e = ($urandom_range(0, 3) == 0) ? ENERGY_W'($urandom)
                                      : ENERGY_W'($urandom_range(0, 300));
      send_hit(make_hit(pool[$urandom_range(0, 2)], $urandom_range(0, 9) == 0,
                        base + $urandom_range(0, span), e, POS_W'($urandom), k == n - 1));
    end
  endtask

  logic [TIME_W-1:0] windows [8] = '{32'd16, 32'd0, 32'hFFFF_FFFF, 32'd50,
                                     32'd2000, 32'd8, 32'd300, 32'd100};
  logic [ESUM_W-1:0] thresholds [8] = '{22'd0, 22'd0, 22'h3F_FFFF, 22'd200,
                                        22'd1000, 22'd50, 22'd0, 22'd150000};

  initial begin
    int phase_start;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_TIME_WINDOW;
    cfg_data = '0;
    hits.valid = 1'b0;
    hits.data = '0;
    clusters.ready = 1'b0;
    idle_mode = 0;
    hits_sent = 0;
    batches_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings
    send_hit(make_hit(10'd3, 1'b0, 32'd100, 16'd0, 24'd0, 1'b1));
    send_hit(make_hit(10'd3, 1'b1, 32'd100, 16'd9, 24'd0, 1'b1));
    send_hit(make_hit(10'd1023, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 24'h7F_FFFF, 1'b0));
    send_hit(make_hit(10'd1023, 1'b0, 32'hFFFF_FFFF, 16'd1, 24'h80_0000, 1'b0));
    send_hit(make_hit(10'd0, 1'b0, 32'd0, 16'hFFFF, 24'h80_0000, 1'b0));
    send_hit(make_hit(10'd0, 1'b0, 32'd0, 16'd5, 24'd0, 1'b0));
    send_hit(make_hit(10'd0, 1'b0, 32'd15, 16'd0, 24'd77, 1'b0));
    send_hit(make_hit(10'd0, 1'b0, 32'd16, 16'd7, 24'hFF_FFF0, 1'b0));
    send_hit(make_hit(10'd5, 1'b1, 32'd3, 16'd100, 24'd1, 1'b0));
    send_hit(make_hit(10'd512, 1'b0, 32'd40, 16'd300, 24'h55_5555, 1'b0));
    send_hit(make_hit(10'd512, 1'b0, 32'd40, 16'd200, 24'hAA_AAAA, 1'b1));
    send_hit(make_hit(10'd7, 1'b0, 32'hFFFF_FFF8, 16'd3, 24'd5, 1'b0));
    send_hit(make_hit(10'd7, 1'b0, 32'h0000_0002, 16'd3, 24'd5, 1'b1));

    for (int ph = 0; ph < 8; ph++) begin
      set_cfg(windows[ph], thresholds[ph]);
      idle_mode = ph % 4;
      phase_start = hits_sent;
      if (ph == 4) random_batch(70);
      while (hits_sent - phase_start < 14)
        random_batch(($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8));
    end

    idle_mode = 0;
    wait_drained();
    $display("sent %0d hits in %0d batches, checked %0d clusters", hits_sent,
             batches_sent, checked);
    $display("covered 8 window/threshold settings and four idle patterns");
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
